// ===== src/detection_hit_count_tracker_core_macros.svh =====
// assertion macros for the detection hit-count tracker
// users need clk and rst_n in scope; no other dependencies
`ifndef DETECTION_HIT_COUNT_TRACKER_CORE_MACROS_SVH
`define DETECTION_HIT_COUNT_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DHCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dhct_pkg.sv =====
// shared constants, types and state encoding for the hit-count tracker
// no dependencies
package dhct_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 12;
  localparam int CNT_W      = 3;
  localparam int TOT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int RADIUS_W   = 12;
  localparam int PERIOD_W   = 8;
  localparam int FRAME_W    = 8;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = 1;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0] HIT_LIMIT = 3'd6;
  localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd32;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd6;

  localparam logic [REG_IDX_W-1:0] REG_MATCH_RADIUS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECAY_PERIOD = 1'd1;

  localparam logic MODE_POINT     = 1'b0;
  localparam logic MODE_FRAME_END = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CNT_W-1:0]      cnt;
  } entry_t;

  // search request walking along the row of cells
  typedef struct packed {
    logic                  vld;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  matched;
    logic                  appended;
    logic [CNT_W-1:0]      top;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } wave_t;

  typedef struct packed {
    logic dec;
    logic shift;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LAUNCH,
    ST_SEARCH,
    ST_DECAY,
    ST_COMPACT,
    ST_FINISH
  } state_t;

endpackage

// ===== src/dhct_ifs.sv =====
// valid/ready channel interfaces for detection requests and results
// depends on dhct_pkg
interface dhct_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [dhct_pkg::COORD_BITS-1:0] point_x;
  logic [dhct_pkg::COORD_BITS-1:0] point_y;

  modport source (output valid, mode, point_x, point_y, input ready);
  modport sink (input valid, mode, point_x, point_y, output ready);
endinterface

interface dhct_out_if;
  logic                            valid;
  logic                            ready;
  logic [dhct_pkg::COORD_BITS-1:0] best_x;
  logic [dhct_pkg::COORD_BITS-1:0] best_y;
  logic                            best_found;
  logic                            point_dropped;

  modport source (output valid, best_x, best_y, best_found, point_dropped, input ready);
  modport sink (input valid, best_x, best_y, best_found, point_dropped, output ready);
endinterface

// ===== src/dhct_cell.sv =====
// one list slot of the tracker: holds a point and its hit count, matches the passing search
// request, decrements the count on decay and shifts left during compaction; uses dhct_pkg
module dhct_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dhct_pkg::wave_t             wave_i,
  output dhct_pkg::wave_t             wave_o,
  input  logic                        occ_i,
  input  logic                        app_i,
  input  logic [dhct_pkg::SQ_W-1:0]   limit_i,
  input  dhct_pkg::cell_cmd_t         cmd_i,
  input  logic                        hole_i,
  output logic                        hole_o,
  input  dhct_pkg::entry_t            next_i,
  output dhct_pkg::entry_t            ent_o
);

  dhct_pkg::entry_t                  ent_r, ent_nxt;
  dhct_pkg::wave_t                   wave_r, wave_nxt;
  logic [dhct_pkg::COORD_BITS-1:0]   dx, dy;
  logic [dhct_pkg::SQ_W-1:0]         dx2, dy2;
  logic [dhct_pkg::SQ_W:0]           dsq;
  logic                              hit, put, hole_here;
  logic [dhct_pkg::CNT_W-1:0]        cnt_upd;

  always_comb begin
    dx  = (wave_i.px > ent_r.x) ? wave_i.px - ent_r.x : ent_r.x - wave_i.px;
    dy  = (wave_i.py > ent_r.y) ? wave_i.py - ent_r.y : ent_r.y - wave_i.py;
    dx2 = dhct_pkg::SQ_W'(dx) * dhct_pkg::SQ_W'(dx);
    dy2 = dhct_pkg::SQ_W'(dy) * dhct_pkg::SQ_W'(dy);
    dsq = {1'b0, dx2} + {1'b0, dy2};
  end

  assign hit = wave_i.vld && occ_i && !wave_i.matched && (dsq <= {1'b0, limit_i});
  // first free slot takes an unmatched point
  assign put = wave_i.vld && app_i && !wave_i.matched;
  assign hole_here = hole_i || (occ_i && (ent_r.cnt == '0));
  assign hole_o = hole_here;

  always_comb begin
    if (hit) begin
      cnt_upd = (ent_r.cnt < dhct_pkg::HIT_LIMIT) ?
                ent_r.cnt + dhct_pkg::CNT_W'(1) : ent_r.cnt;
    end else if (put) begin
      cnt_upd = dhct_pkg::CNT_ONE;
    end else begin
      cnt_upd = ent_r.cnt;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (hit || put) begin
      ent_nxt.x   = wave_i.px;
      ent_nxt.y   = wave_i.py;
      ent_nxt.cnt = cnt_upd;
    end else if (cmd_i.dec && occ_i) begin
      ent_nxt.cnt = ent_r.cnt - dhct_pkg::CNT_W'(1);
    end else if (cmd_i.shift && hole_here) begin
      ent_nxt = next_i;
    end
  end

  always_comb begin
    wave_nxt          = wave_i;
    wave_nxt.matched  = wave_i.matched | hit | put;
    wave_nxt.appended = wave_i.appended | put;
    // strict compare keeps the earliest slot on a tie
    if ((occ_i || put) && (cnt_upd > wave_i.top)) begin
      wave_nxt.top = cnt_upd;
      wave_nxt.bx  = (hit || put) ? wave_i.px : ent_r.x;
      wave_nxt.by  = (hit || put) ? wave_i.py : ent_r.y;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign wave_o = wave_r;
  assign ent_o  = ent_r;

endmodule

// ===== src/detection_hit_count_tracker_core.sv =====
// channel      | dir | payload                                   | notes
// in_req       | in  | mode, point_x, point_y                    | valid/ready
// out_rsp      | out | best_x, best_y, best_found, point_dropped | valid/ready, registered
// cfg_*        | in  | match_radius (addr 0), decay_period (4)   | apb, pready tied high
// a detection steps through square, launch, search and finish; the search request
// walks the row of cells one slot per cycle. a frame end goes straight to finish,
// or with a decay through decay, then compaction of the emptied entries, then finish.
// one request in flight; the next is taken while the result waits in the
// output register. synchronous active-low reset empties the list, no sweep.
// top level of the detection hit-count tracker; depends on dhct_pkg,
// dhct_ifs, dhct_cell and the assertion macro header
`include "detection_hit_count_tracker_core_macros.svh"

module detection_hit_count_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  dhct_in_if.sink                         in_req,
  dhct_out_if.source                      out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dhct_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [dhct_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [dhct_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int N = dhct_pkg::MAX_POINTS;

  dhct_pkg::state_t                  state_r, state_nxt;
  logic [dhct_pkg::TOT_W-1:0]        total_r;
  logic [dhct_pkg::FRAME_W-1:0]      fc_r, fc_inc;
  logic [dhct_pkg::RADIUS_W-1:0]     radius_r;
  logic [dhct_pkg::PERIOD_W-1:0]     period_r;
  logic [dhct_pkg::SQ_W-1:0]         limit_r;
  logic [dhct_pkg::COORD_BITS-1:0]   px_r, py_r;
  logic [dhct_pkg::COORD_BITS-1:0]   held_bx_r, held_by_r;
  logic                              held_found_r;
  logic                              dropped_r;
  logic                              out_valid_r;
  logic [dhct_pkg::COORD_BITS-1:0]   out_bx_r, out_by_r;
  logic                              out_found_r, out_dropped_r;

  logic                              in_acc, load_out, inject, decay_hit, cfg_wr;
  logic [dhct_pkg::REG_IDX_W-1:0]    cfg_idx;
  dhct_pkg::cell_cmd_t               cmd;
  dhct_pkg::wave_t                   wave_a [N+1];
  dhct_pkg::entry_t                  ent_a [N+1];
  logic                              hole_a [N+1];
  dhct_pkg::wave_t                   last_wave;
  logic                              last_hole, found_now;

  // row of cells
  always_comb begin
    wave_a[0]          = '0;
    wave_a[0].vld      = inject;
    wave_a[0].px       = px_r;
    wave_a[0].py       = py_r;
  end
  assign ent_a[N]  = '0;
  assign hole_a[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dhct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wave_i  (wave_a[i]),
      .wave_o  (wave_a[i+1]),
      .occ_i   (dhct_pkg::TOT_W'(i) < total_r),
      .app_i   (dhct_pkg::TOT_W'(i) == total_r),
      .limit_i (limit_r),
      .cmd_i   (cmd),
      .hole_i  (hole_a[i]),
      .hole_o  (hole_a[i+1]),
      .next_i  (ent_a[i+1]),
      .ent_o   (ent_a[i])
    );
  end

  assign last_wave = wave_a[N];
  assign last_hole = hole_a[N];
  assign found_now = last_wave.top > dhct_pkg::CNT_ONE;

  assign in_acc    = in_req.valid && in_req.ready;
  assign fc_inc    = fc_r + dhct_pkg::FRAME_W'(1);
  assign decay_hit = fc_inc >= period_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dhct_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_req.mode == dhct_pkg::MODE_POINT) begin
            state_nxt = dhct_pkg::ST_SQUARE;
          end else if (decay_hit) begin
            state_nxt = dhct_pkg::ST_DECAY;
          end else begin
            state_nxt = dhct_pkg::ST_FINISH;
          end
        end
      end
      dhct_pkg::ST_SQUARE:  state_nxt = dhct_pkg::ST_LAUNCH;
      dhct_pkg::ST_LAUNCH:  state_nxt = dhct_pkg::ST_SEARCH;
      dhct_pkg::ST_SEARCH: begin
        if (last_wave.vld) begin
          state_nxt = dhct_pkg::ST_FINISH;
        end
      end
      dhct_pkg::ST_DECAY:   state_nxt = dhct_pkg::ST_COMPACT;
      dhct_pkg::ST_COMPACT: begin
        if (!last_hole) begin
          state_nxt = dhct_pkg::ST_FINISH;
        end
      end
      dhct_pkg::ST_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = dhct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dhct_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_req.ready = (state_r == dhct_pkg::ST_IDLE);
    inject       = (state_r == dhct_pkg::ST_LAUNCH);
    cmd.dec      = (state_r == dhct_pkg::ST_DECAY);
    cmd.shift    = (state_r == dhct_pkg::ST_COMPACT) && last_hole;
    load_out     = (state_r == dhct_pkg::ST_FINISH) && (!out_valid_r || out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dhct_pkg::ST_IDLE;
      total_r      <= '0;
      fc_r         <= '0;
      held_bx_r    <= '0;
      held_by_r    <= '0;
      held_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_req.mode == dhct_pkg::MODE_FRAME_END)) begin
        fc_r <= decay_hit ? '0 : fc_inc;
      end
      if ((state_r == dhct_pkg::ST_SEARCH) && last_wave.vld) begin
        total_r      <= total_r + dhct_pkg::TOT_W'(last_wave.appended);
        held_found_r <= found_now;
        held_bx_r    <= found_now ? last_wave.bx : '0;
        held_by_r    <= found_now ? last_wave.by : '0;
      end else if (cmd.shift) begin
        total_r <= total_r - dhct_pkg::TOT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    limit_r <= dhct_pkg::SQ_W'(radius_r) * dhct_pkg::SQ_W'(radius_r);
    if (in_acc) begin
      px_r      <= in_req.point_x;
      py_r      <= in_req.point_y;
      dropped_r <= 1'b0;
    end else if ((state_r == dhct_pkg::ST_SEARCH) && last_wave.vld) begin
      dropped_r <= !last_wave.matched;
    end
    if (load_out) begin
      out_bx_r      <= ((state_r == dhct_pkg::ST_FINISH) ? held_bx_r : '0);
      out_by_r      <= held_by_r;
      out_found_r   <= held_found_r;
      out_dropped_r <= dropped_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.best_x        = out_bx_r;
  assign out_rsp.best_y        = out_by_r;
  assign out_rsp.best_found    = out_found_r;
  assign out_rsp.point_dropped = out_dropped_r;

  // configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[dhct_pkg::ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= dhct_pkg::RADIUS_RST;
      period_r <= dhct_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dhct_pkg::REG_MATCH_RADIUS: radius_r <= cfg_pwdata[dhct_pkg::RADIUS_W-1:0];
        dhct_pkg::REG_DECAY_PERIOD: period_r <= cfg_pwdata[dhct_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dhct_pkg::REG_MATCH_RADIUS:
        cfg_prdata = {{(dhct_pkg::DATA_W - dhct_pkg::RADIUS_W){1'b0}}, radius_r};
      dhct_pkg::REG_DECAY_PERIOD:
        cfg_prdata = {{(dhct_pkg::DATA_W - dhct_pkg::PERIOD_W){1'b0}}, period_r};
      default: cfg_prdata = '0;
    endcase
  end

  // checks
  `DHCT_ASSERT_NOW(a_total_in_range, 1'b1, total_r <= dhct_pkg::TOT_W'(N), "list count overflow")
  `DHCT_ASSERT_NOW(a_wave_only_in_search, last_wave.vld, state_r == dhct_pkg::ST_SEARCH, "stray search request")
  `DHCT_ASSERT_NOW(a_shift_needs_entries, cmd.shift, total_r != '0, "compaction on empty list")
  `DHCT_ASSERT_NOW(a_drop_only_when_full, (state_r == dhct_pkg::ST_FINISH) && dropped_r, total_r == dhct_pkg::TOT_W'(N), "drop with free slot")
  `DHCT_ASSERT_NEXT(a_search_then_finish, (state_r == dhct_pkg::ST_SEARCH) && last_wave.vld, state_r == dhct_pkg::ST_FINISH, "search end missed")

endmodule
